// ===== src/chs_pkg.sv =====
// Shared types and constants for the chained hash set.
`default_nettype none
package chs_pkg;
  localparam int unsigned KeyW  = 31;
  localparam int unsigned FuncW = 2;
  localparam int unsigned CfgW  = 7;

  localparam logic [FuncW-1:0] FuncInsert = 2'd0;
  localparam logic [FuncW-1:0] FuncRemove = 2'd1;
endpackage
`default_nettype wire

// ===== src/chained_hash_set.sv =====
// Top level of the chained hash set: sequencer, slot memories and modulo unit.
//
//  channel | signals                          | dir
//  in      | in_valid in_ready func key       | in
//  out     | out_valid out_ready was_present  | out
//          | bucket_full                      |
//  cfg     | cfg_we cfg_data (bucket_count)   | in
//
// One item passes through the modulo unit, the slot reads of its bucket, a
// write-back state, the output state while its result is offered, and the idle
// state before the next item is taken.
// Reset clears the valid memory in a sweep over all NUM_BUCKETS*SLOTS_PER_BUCKET
// slots, during which no item is taken.
// A result waits in the output register; the next item is taken once it leaves.
`default_nettype none
module chained_hash_set #(
  parameter int unsigned NUM_BUCKETS      = 64,
  parameter int unsigned SLOTS_PER_BUCKET = 8
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [chs_pkg::FuncW-1:0] func,
  input  wire logic [chs_pkg::KeyW-1:0]  key,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           was_present,
  output logic                           bucket_full,
  input  wire logic                      cfg_we,
  input  wire logic [chs_pkg::CfgW-1:0]  cfg_data
);
  localparam int unsigned Total = NUM_BUCKETS * SLOTS_PER_BUCKET;
  localparam int unsigned AW    = (Total > 1) ? $clog2(Total) : 1;
  localparam int unsigned BW    = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS + 1) : 1;
  localparam int unsigned SCW   = $clog2(SLOTS_PER_BUCKET + 1);
  localparam int unsigned DW    = (BW > chs_pkg::CfgW) ? BW : chs_pkg::CfgW;
  localparam int unsigned MW    = AW + DW + 1;

  typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_MOD, S_SCAN, S_WRITE, S_OUT} state_t;

  state_t                    state;
  logic [chs_pkg::CfgW-1:0]  bucket_count;
  logic [chs_pkg::FuncW-1:0] op;
  logic [chs_pkg::KeyW-1:0]  op_key;
  logic [AW-1:0]             base;
  logic [AW-1:0]             clr_addr;
  logic [SCW-1:0]            rd_cnt;     // slot index being issued
  logic [SCW-1:0]            chk_cnt;    // slot index whose data is back
  logic                      chk_live;
  logic                      hit;
  logic [AW-1:0]             hit_addr;
  logic                      has_free;
  logic [AW-1:0]             free_addr;

  logic [chs_pkg::KeyW-1:0]  key_mem [Total];
  logic                      vld_mem [Total];
  logic [chs_pkg::KeyW-1:0]  rd_key;
  logic                      rd_vld;
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic                      mem_wvld;
  logic                      key_we;
  logic [AW-1:0]             rd_addr;

  logic                      mod_start;
  logic                      mod_done;
  logic [DW-1:0]             mod_rem;
  logic [DW-1:0]             eff;
  logic [MW-1:0]             base_full;

  // Bucket count clamped to 1..NUM_BUCKETS.
  always_comb begin
    if (bucket_count == '0) eff = DW'(1);
    else if (DW'(bucket_count) > DW'(NUM_BUCKETS)) eff = DW'(NUM_BUCKETS);
    else eff = DW'(bucket_count);
  end

  assign mod_start = (state == S_IDLE) && in_valid;
  assign in_ready  = (state == S_IDLE);
  assign base_full = MW'(mod_rem) * MW'(SLOTS_PER_BUCKET);
  assign rd_addr   = base + AW'(rd_cnt);

  chs_mod #(.DivW(DW)) u_mod (
    .clk(clk), .rst(rst), .start(mod_start), .dividend(key), .divisor(eff),
    .done(mod_done), .remainder(mod_rem)
  );

  // Slot memories with registered reads.
  always_ff @(posedge clk) begin
    if (mem_we) vld_mem[mem_waddr] <= mem_wvld;
    if (key_we) key_mem[mem_waddr] <= op_key;
    rd_vld <= vld_mem[rd_addr];
    rd_key <= key_mem[rd_addr];
  end

  always_comb begin
    mem_we    = 1'b0;
    key_we    = 1'b0;
    mem_waddr = clr_addr;
    mem_wvld  = 1'b0;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
    end else if (state == S_WRITE) begin
      if (op == chs_pkg::FuncInsert && !hit && has_free) begin
        mem_we = 1'b1; key_we = 1'b1; mem_waddr = free_addr; mem_wvld = 1'b1;
      end else if (op == chs_pkg::FuncRemove && hit) begin
        mem_we = 1'b1; mem_waddr = hit_addr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      bucket_count <= chs_pkg::CfgW'(64);
      out_valid    <= 1'b0;
      chk_live     <= 1'b0;
    end else begin
      if (cfg_we) bucket_count <= cfg_data;
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(Total - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid) begin
            op     <= func;
            op_key <= key;
            state  <= S_MOD;
          end
        end
        S_MOD: begin
          if (mod_done) begin
            base     <= base_full[AW-1:0];
            rd_cnt   <= '0;
            chk_live <= 1'b0;
            hit      <= 1'b0;
            has_free <= 1'b0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          // Goes low by itself once every slot has been issued.
          chk_live <= (rd_cnt != SCW'(SLOTS_PER_BUCKET));
          chk_cnt  <= rd_cnt;
          if (rd_cnt != SCW'(SLOTS_PER_BUCKET)) rd_cnt <= rd_cnt + 1'b1;
          if (chk_live) begin
            if (rd_vld) begin
              if (!hit && rd_key == op_key) begin
                hit      <= 1'b1;
                hit_addr <= base + AW'(chk_cnt);
              end
            end else if (!has_free) begin
              has_free  <= 1'b1;
              free_addr <= base + AW'(chk_cnt);
            end
          end
          if (chk_live && chk_cnt == SCW'(SLOTS_PER_BUCKET - 1)) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          was_present <= hit;
          bucket_full <= (op == chs_pkg::FuncInsert) && !hit && !has_free;
          out_valid   <= 1'b1;
          state       <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A result only appears after an item was taken.
  a_out_after_write: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_WRITE)) else $error("stray result");
  // Full is only flagged for a missed insert.
  a_full_insert: assert property (@(posedge clk) disable iff (rst)
    (out_valid && bucket_full) |-> (op == chs_pkg::FuncInsert && !was_present))
    else $error("bad full flag");
  // No item is taken while a result is pending.
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("taken while busy");
endmodule
`default_nettype wire

// ===== src/chs_mod.sv =====
// Iterative restoring remainder: key mod divisor, one quotient bit per cycle.
`default_nettype none
module chs_mod #(
  parameter int unsigned DivW = 7
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [chs_pkg::KeyW-1:0] dividend,
  input  wire logic [DivW-1:0]          divisor,
  output logic                          done,
  output logic [DivW-1:0]               remainder
);
  localparam int unsigned CntW = $clog2(chs_pkg::KeyW + 1);

  logic                     busy;
  logic [CntW-1:0]          cnt;
  logic [chs_pkg::KeyW-1:0] shreg;
  logic [DivW-1:0]          dvs;
  logic [DivW:0]            rem;
  logic [DivW:0]            trial;

  assign trial     = {rem[DivW-1:0], shreg[chs_pkg::KeyW-1]};
  assign remainder = rem[DivW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CntW'(chs_pkg::KeyW);
        shreg <= dividend;
        dvs   <= divisor;
        rem   <= '0;
      end else if (busy) begin
        shreg <= {shreg[chs_pkg::KeyW-2:0], 1'b0};
        if (trial >= {1'b0, dvs}) rem <= trial - {1'b0, dvs};
        else rem <= trial;
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Testbench for the chained hash set: predicted set contents checked against every result.
`timescale 1ns / 1ps
`default_nettype none

// Holds the predicted slot contents and the queue of awaited results.
class hash_set_board;
  localparam int NB = 64;
  localparam int SPB = 8;
  bit [chs_pkg::KeyW-1:0] keys[NB*SPB];
  bit                     used[NB*SPB];
  bit [chs_pkg::CfgW-1:0] buckets;
  bit                     want_present[$];
  bit                     want_full[$];
  int                     errors;

  function void clear();
    foreach (used[i]) begin
      used[i] = 0;
      keys[i] = '0;
    end
    buckets = 7'd64;
    errors  = 0;
  endfunction

  function void set_buckets(bit [chs_pkg::CfgW-1:0] v);
    buckets = v;
  endfunction

  // Apply one accepted item to the predicted store and queue its result.
  function void note_item(bit [chs_pkg::FuncW-1:0] f, bit [chs_pkg::KeyW-1:0] k);
    int n, base, hit, free_at;
    bit full;
    n = buckets;
    if (n == 0) n = 1;
    if (n > NB) n = NB;
    base = (k % n) * SPB;
    hit = -1;
    free_at = -1;
    full = 0;
    for (int s = 0; s < SPB; s++) begin
      if (used[base+s]) begin
        if (hit < 0 && keys[base+s] == k) hit = base + s;
      end else if (free_at < 0) begin
        free_at = base + s;
      end
    end
    if (f == chs_pkg::FuncInsert) begin
      if (hit < 0) begin
        if (free_at >= 0) begin
          keys[free_at] = k;
          used[free_at] = 1;
        end else begin
          full = 1;
        end
      end
    end else if (f == chs_pkg::FuncRemove) begin
      if (hit >= 0) used[hit] = 0;
    end
    want_present = {want_present, bit'(hit >= 0)};
    want_full    = {want_full, full};
  endfunction

  task report(string what);
    $display("mismatch: %s at %0t", what, $realtime);
    errors++;
  endtask

  task check_result(bit p, bit f);
    bit ep, ef;
    if (want_present.size() == 0) begin
      report("result with nothing awaited");
      return;
    end
    ep = want_present.pop_front();
    ef = want_full.pop_front();
    if (p !== ep) report($sformatf("was_present %0b, expected %0b", p, ep));
    if (f !== ef) report($sformatf("bucket_full %0b, expected %0b", f, ef));
  endtask

  function int pending();
    return want_present.size();
  endfunction
endclass

module testbench;
  localparam logic [chs_pkg::FuncW-1:0] FuncFind   = 2'd2;
  localparam logic [chs_pkg::FuncW-1:0] FuncUnused = 2'd3;
  localparam int LATENCY = 60;

  logic                      clk = 0;
  logic                      rst = 1;
  logic                      in_valid = 0;
  logic                      in_ready;
  logic [chs_pkg::FuncW-1:0] func = '0;
  logic [chs_pkg::KeyW-1:0]  key = '0;
  logic                      out_valid;
  logic                      out_ready = 0;
  logic                      was_present;
  logic                      bucket_full;
  logic                      cfg_we = 0;
  logic [chs_pkg::CfgW-1:0]  cfg_data = '0;

  hash_set_board board = new();
  bit calm;        // no idling on either side
  bit hold_off;    // receiver held back for a long stretch
  int held_cycles;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  chained_hash_set DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .func(func), .key(key),
    .out_valid(out_valid), .out_ready(out_ready),
    .was_present(was_present), .bucket_full(bucket_full),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // Receiver: random stalls, or a counted hold-off when asked.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else begin
      if (out_valid && out_ready) board.check_result(was_present, bucket_full);
      if (hold_off) begin
        held_cycles++;
        out_ready <= 0;
      end else begin
        out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 13);
      end
    end
  end

  // Offer one item and wait for it to be taken; gaps ahead of it at random unless calm.
  // Valid is dropped by a gap or by drain, so it never gets two updates at one edge.
  task automatic send_item(logic [chs_pkg::FuncW-1:0] f, logic [chs_pkg::KeyW-1:0] k);
    if (!calm) begin
      while ($urandom_range(99) < 13) begin
        in_valid <= 0;
        @(posedge clk);
      end
    end
    in_valid <= 1;
    func     <= f;
    key      <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_item(f, k);
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_buckets(logic [chs_pkg::CfgW-1:0] v);
    drain();
    cfg_we   <= 1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    board.set_buckets(v);
  endtask

  // Mostly keys from a small pool so inserts, removes and finds meet each other.
  function automatic logic [chs_pkg::KeyW-1:0] pick_key(int pool);
    if ($urandom_range(9) == 0) return chs_pkg::KeyW'($urandom);
    return chs_pkg::KeyW'($urandom_range(pool));
  endfunction

  function automatic logic [chs_pkg::FuncW-1:0] pick_func();
    int r;
    r = $urandom_range(99);
    if (r < 45) return chs_pkg::FuncInsert;
    if (r < 70) return chs_pkg::FuncRemove;
    if (r < 95) return FuncFind;
    return FuncUnused;
  endfunction

  initial begin
    board.clear();
    calm = 0;
    hold_off = 0;
    held_cycles = 0;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed: key extremes, every operation, unused func, full bucket.
    send_item(chs_pkg::FuncInsert, 31'h0);
    send_item(chs_pkg::FuncInsert, 31'h7fffffff);
    send_item(FuncFind, 31'h7fffffff);
    send_item(chs_pkg::FuncInsert, 31'h0);
    send_item(FuncUnused, 31'h0);
    send_item(chs_pkg::FuncRemove, 31'h0);
    send_item(chs_pkg::FuncRemove, 31'h0);
    send_item(FuncFind, 31'h0);
    for (int i = 0; i < 9; i++) send_item(chs_pkg::FuncInsert, 31'(i * 64 + 5));
    send_item(FuncFind, 31'(8 * 64 + 5));
    send_item(chs_pkg::FuncRemove, 31'(3 * 64 + 5));
    send_item(chs_pkg::FuncInsert, 31'(9 * 64 + 5));
    send_item(FuncFind, 31'h55555555);
    send_item(FuncFind, 31'h2aaaaaaa);

    // Count changed with keys held; then zero, over-range and small counts.
    write_buckets(7'd3);
    send_item(FuncFind, 31'h7fffffff);
    send_item(chs_pkg::FuncInsert, 31'h7fffffff);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_buckets(7'd0);
        1: write_buckets(7'd127);
        2: write_buckets(7'd1);
        3: write_buckets(7'd64);
        4: write_buckets(7'd65);
        default: write_buckets(7'($urandom_range(2, 63)));
      endcase
      calm = (phase == 3);
      for (int i = 0; i < 88; i++) begin
        if (phase == 2 && i == 20) begin
          // Hold the receiver; the sender keeps offering until the block stalls.
          hold_off = 1;
          fork
            begin
              while (held_cycles < 400) @(posedge clk);
              hold_off = 0;
            end
            repeat (3) send_item(pick_func(), pick_key(40));
          join
        end
        if (phase == 4 && i == 40) drain();
        send_item(pick_func(), pick_key(phase == 2 ? 40 : 600));
      end
    end
    calm = 1;
    drain();
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
`default_nettype wire
